/* src/mbe_pkg.sv */
// Shared constants and the slot type for the Mandelbrot escape-time block.
// Used by the channel interfaces, the three ring stages and the top level.
package mbe_pkg;

    localparam int FRACTION_BITS = 28;
    localparam int WORD_W        = 32;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int COUNT_W       = 16;
    localparam int RING_DEPTH    = 3;
    localparam int TAG_W         = $clog2(RING_DEPTH) + 1;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(256);

    // Squared-magnitude escape threshold, four in the product format.
    localparam logic [PROD_W-1:0] ESC_THRESH =
        (2 * FRACTION_BITS + 2 >= PROD_W) ? '1 : (PROD_W'(1) << (2 * FRACTION_BITS + 2));

    typedef struct packed {
        logic               valid;
        logic               done;
        logic [TAG_W-1:0]   tag;
        logic [WORD_W-1:0]  c_real;
        logic [WORD_W-1:0]  c_imag;
        logic [WORD_W-1:0]  z_real;
        logic [WORD_W-1:0]  z_imag;
        logic [COUNT_W-1:0] count;
    } t_slot;

endpackage

/* src/mbe_ifs.sv */
// Valid/ready channel interfaces for points, results and the limit register.
// Depends on mbe_pkg for the field widths.
interface mbe_point_if;
    logic                            valid;
    logic                            ready;
    logic signed [mbe_pkg::WORD_W-1:0] c_real;
    logic signed [mbe_pkg::WORD_W-1:0] c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_count_if;
    logic                       valid;
    logic                       ready;
    logic [mbe_pkg::COUNT_W-1:0] escape_count;

    modport source (output valid, output escape_count, input ready);
    modport sink   (input valid, input escape_count, output ready);
endinterface

interface mbe_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [mbe_pkg::COUNT_W-1:0] iteration_limit;

    modport source (output valid, output iteration_limit, input ready);
    modport sink   (input valid, input iteration_limit, output ready);
endinterface

/* src/mbe_square.sv */
// First ring stage: forms zr*zr, zi*zi and zr*zi of the entering slot.
// Depends on mbe_pkg.
module mbe_square (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mbe_pkg::t_slot                    i_slot,
    output mbe_pkg::t_slot                    o_slot,
    output logic signed [mbe_pkg::PROD_W-1:0] o_rr,
    output logic signed [mbe_pkg::PROD_W-1:0] o_ii,
    output logic signed [mbe_pkg::PROD_W-1:0] o_ri
);
    logic signed [mbe_pkg::WORD_W-1:0] zr;
    logic signed [mbe_pkg::WORD_W-1:0] zi;
    logic signed [mbe_pkg::PROD_W-1:0] n_rr;
    logic signed [mbe_pkg::PROD_W-1:0] n_ii;
    logic signed [mbe_pkg::PROD_W-1:0] n_ri;
    mbe_pkg::t_slot                    r_slot;
    logic signed [mbe_pkg::PROD_W-1:0] r_rr;
    logic signed [mbe_pkg::PROD_W-1:0] r_ii;
    logic signed [mbe_pkg::PROD_W-1:0] r_ri;

    always_comb begin
        zr   = $signed(i_slot.z_real);
        zi   = $signed(i_slot.z_imag);
        n_rr = zr * zr;
        n_ii = zi * zi;
        n_ri = zr * zi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot <= i_slot;
        end
        r_rr <= n_rr;
        r_ii <= n_ii;
        r_ri <= n_ri;
    end

    assign o_slot = r_slot;
    assign o_rr   = r_rr;
    assign o_ii   = r_ii;
    assign o_ri   = r_ri;
endmodule

/* src/mbe_combine.sv */
// Second ring stage: squared magnitude and the shifted real and imaginary terms.
// Depends on mbe_pkg.
module mbe_combine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mbe_pkg::t_slot                    i_slot,
    input  logic signed [mbe_pkg::PROD_W-1:0] i_rr,
    input  logic signed [mbe_pkg::PROD_W-1:0] i_ii,
    input  logic signed [mbe_pkg::PROD_W-1:0] i_ri,
    output mbe_pkg::t_slot                    o_slot,
    output logic [mbe_pkg::PROD_W-1:0]        o_mag,
    output logic [mbe_pkg::WORD_W-1:0]        o_nr,
    output logic [mbe_pkg::WORD_W-1:0]        o_ni
);
    logic signed [mbe_pkg::PROD_W-1:0] diff;
    logic signed [mbe_pkg::PROD_W-1:0] sh_r;
    logic signed [mbe_pkg::PROD_W-1:0] sh_i;
    logic [mbe_pkg::PROD_W-1:0]        n_mag;
    mbe_pkg::t_slot                    r_slot;
    logic [mbe_pkg::PROD_W-1:0]        r_mag;
    logic [mbe_pkg::WORD_W-1:0]        r_nr;
    logic [mbe_pkg::WORD_W-1:0]        r_ni;

    always_comb begin
        n_mag = $unsigned(i_rr) + $unsigned(i_ii);
        diff  = i_rr - i_ii;
        sh_r  = diff >>> mbe_pkg::FRACTION_BITS;
        sh_i  = i_ri >>> (mbe_pkg::FRACTION_BITS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot <= i_slot;
        end
        r_mag <= n_mag;
        r_nr  <= sh_r[mbe_pkg::WORD_W-1:0];
        r_ni  <= sh_i[mbe_pkg::WORD_W-1:0];
    end

    assign o_slot = r_slot;
    assign o_mag  = r_mag;
    assign o_nr   = r_nr;
    assign o_ni   = r_ni;
endmodule

/* src/mbe_update.sv */
// Third ring stage: escape test, new z and count, or the final result.
// Depends on mbe_pkg.
module mbe_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbe_pkg::t_slot              i_slot,
    input  logic [mbe_pkg::PROD_W-1:0]  i_mag,
    input  logic [mbe_pkg::WORD_W-1:0]  i_nr,
    input  logic [mbe_pkg::WORD_W-1:0]  i_ni,
    input  logic [mbe_pkg::COUNT_W-1:0] i_limit,
    output mbe_pkg::t_slot              o_slot
);
    logic           below_limit;
    logic           in_radius;
    mbe_pkg::t_slot n_slot;
    mbe_pkg::t_slot r_slot;

    always_comb begin
        below_limit = i_slot.count < i_limit;
        in_radius   = i_mag <= mbe_pkg::ESC_THRESH;
        n_slot      = i_slot;
        if (i_slot.valid && !i_slot.done) begin
            if (below_limit && in_radius) begin
                n_slot.z_real = i_nr + i_slot.c_real;
                n_slot.z_imag = i_ni + i_slot.c_imag;
                n_slot.count  = i_slot.count + mbe_pkg::COUNT_W'(1);
            end else begin
                n_slot.done  = 1'b1;
                n_slot.count = below_limit ? i_slot.count : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;
endmodule

/* src/mandelbrot_escape_time.sv */
// Mandelbrot escape-time counter: a three-stage iteration ring shared by up to three
// points, results delivered in arrival order. Depends on mbe_pkg, the channel
// interfaces and the stages mbe_square, mbe_combine and mbe_update.
//
// Each iteration of z = z*z + c takes one trip around a ring of three register
// stages: mbe_square, mbe_combine and mbe_update. Up to three points share the
// ring, one per stage, so a new point can enter while earlier points are still
// iterating. A finished point circulates until all earlier points have left and the
// output register is free or being read, then moves to the output register; a new
// point enters whenever the slot returning to the first stage is empty or is moving
// to the output register. The limit register resets to 256 and should
// be written only while no point is in flight.
module mandelbrot_escape_time (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbe_point_if.sink    i_point,
    mbe_count_if.source  o_result,
    mbe_cfg_if.sink      i_cfg
);
    logic [mbe_pkg::COUNT_W-1:0] r_limit;
    logic [mbe_pkg::TAG_W-1:0]   r_in_tag;
    logic [mbe_pkg::TAG_W-1:0]   r_out_tag;
    logic                        r_out_valid;
    logic [mbe_pkg::COUNT_W-1:0] r_out_count;

    mbe_pkg::t_slot              entry_slot;
    mbe_pkg::t_slot              s1_slot;
    mbe_pkg::t_slot              s2_slot;
    mbe_pkg::t_slot              s3_slot;
    logic signed [mbe_pkg::PROD_W-1:0] s1_rr;
    logic signed [mbe_pkg::PROD_W-1:0] s1_ii;
    logic signed [mbe_pkg::PROD_W-1:0] s1_ri;
    logic [mbe_pkg::PROD_W-1:0]  s2_mag;
    logic [mbe_pkg::WORD_W-1:0]  s2_nr;
    logic [mbe_pkg::WORD_W-1:0]  s2_ni;

    logic emit;
    logic take;

    assign emit = s3_slot.valid && s3_slot.done && (s3_slot.tag == r_out_tag)
                  && (!r_out_valid || o_result.ready);
    assign i_point.ready = !s3_slot.valid || emit;
    assign take = i_point.valid && i_point.ready;

    always_comb begin
        entry_slot = s3_slot;
        if (!s3_slot.valid || emit) begin
            entry_slot.valid  = take;
            entry_slot.done   = 1'b0;
            entry_slot.tag    = r_in_tag;
            entry_slot.c_real = i_point.c_real;
            entry_slot.c_imag = i_point.c_imag;
            entry_slot.z_real = i_point.c_real;
            entry_slot.z_imag = i_point.c_imag;
            entry_slot.count  = mbe_pkg::COUNT_W'(1);
        end
    end

    mbe_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (entry_slot),
        .o_slot  (s1_slot),
        .o_rr    (s1_rr),
        .o_ii    (s1_ii),
        .o_ri    (s1_ri)
    );

    mbe_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (s1_slot),
        .i_rr    (s1_rr),
        .i_ii    (s1_ii),
        .i_ri    (s1_ri),
        .o_slot  (s2_slot),
        .o_mag   (s2_mag),
        .o_nr    (s2_nr),
        .o_ni    (s2_ni)
    );

    mbe_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (s2_slot),
        .i_mag   (s2_mag),
        .i_nr    (s2_nr),
        .i_ni    (s2_ni),
        .i_limit (r_limit),
        .o_slot  (s3_slot)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= mbe_pkg::LIMIT_RESET;
            r_in_tag    <= '0;
            r_out_tag   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.iteration_limit;
            end
            if (take) begin
                r_in_tag <= r_in_tag + mbe_pkg::TAG_W'(1);
            end
            if (emit) begin
                r_out_tag   <= r_out_tag + mbe_pkg::TAG_W'(1);
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_count <= s3_slot.count;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.escape_count = r_out_count;
endmodule

/* tb/tb_top.sv */
// Self-checking bench for mandelbrot_escape_time: directed points, then random points
// under a series of iteration limits, each escape count compared with a known count
// or a local model. Depends on mbe_pkg and the channel interfaces in mbe_ifs.sv.
module tb_top;
    localparam int FRACTION_BITS = mbe_pkg::FRACTION_BITS;
    localparam int WORD_W        = mbe_pkg::WORD_W;
    localparam int COUNT_W       = mbe_pkg::COUNT_W;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = mbe_pkg::LIMIT_RESET;

    localparam int RANDOM_ITEMS   = 750;
    localparam int WATCHDOG_LIMIT = 800000;
    localparam int HOLDOFF_CYCLES = 500;
    localparam int DRAIN_CYCLES   = 64;
    localparam int ESC_SHIFT      = 2 * FRACTION_BITS + 2;
    localparam longint unsigned RADIUS_SQ =
        (ESC_SHIFT >= 64) ? '1 : (64'd1 << ESC_SHIFT);

    typedef struct packed {
        logic [COUNT_W-1:0] limit;
        logic [WORD_W-1:0]  c_real;
        logic [WORD_W-1:0]  c_imag;
        logic               known;
        logic [COUNT_W-1:0] count;
    } t_point_row;

    typedef struct {
        logic [WORD_W-1:0]  c_real;
        logic [WORD_W-1:0]  c_imag;
        logic [COUNT_W-1:0] count;
    } t_pending;

    // Rows with the known bit set carry an escape count that is obvious from the point.
    t_point_row directed_rows [24] = '{
        '{16'd256,   32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{16'd256,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd1},
        '{16'd256,   32'h8000_0000, 32'h8000_0000, 1'b1, 16'd1},
        '{16'd256,   32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd1},
        '{16'd256,   32'h8000_0000, 32'h0000_0000, 1'b1, 16'd1},
        '{16'd256,   32'hC000_0000, 32'h4000_0000, 1'b1, 16'd1},
        '{16'd256,   32'h2000_0001, 32'h0000_0000, 1'b1, 16'd1},
        '{16'd256,   32'h2000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{16'd256,   32'hE000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{16'd256,   32'h0000_0000, 32'h2000_0000, 1'b0, 16'd0},
        '{16'd256,   32'h0000_0000, 32'hE000_0000, 1'b0, 16'd0},
        '{16'd256,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0},
        '{16'd256,   32'h16A0_9E66, 32'h16A0_9E66, 1'b0, 16'd0},
        '{16'd256,   32'h1000_0000, 32'h1000_0000, 1'b0, 16'd0},
        '{16'd256,   32'h0400_0000, 32'h0A00_0000, 1'b0, 16'd0},
        '{16'd1,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{16'd1,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd0},
        '{16'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{16'd0,     32'h8000_0000, 32'h8000_0000, 1'b1, 16'd0},
        '{16'd2,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd1},
        '{16'd2,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{16'd2,     32'h2000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{16'd65535, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{16'd65535, 32'h2000_0000, 32'h0000_0000, 1'b0, 16'd0}
    };

    logic i_clk;
    logic i_rst_n;

    mbe_point_if point_ch ();
    mbe_count_if result_ch ();
    mbe_cfg_if   cfg_ch ();

    mandelbrot_escape_time i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (point_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    t_pending           pending_counts [$];
    t_pending           oldest;
    logic [COUNT_W-1:0] iter_limit;
    int                 n_points;
    int                 n_results;
    int                 n_errors;
    int                 quiet_cycles;
    bit                 no_gaps;
    bit                 holdoff_request;

    function automatic logic [COUNT_W-1:0] escape_count_of(
        input logic [WORD_W-1:0]  cr_word,
        input logic [WORD_W-1:0]  ci_word,
        input logic [COUNT_W-1:0] limit
    );
        longint          cr;
        longint          ci;
        longint          zr;
        longint          zi;
        longint          sq_r;
        longint          sq_i;
        longint unsigned mag_sq;
        logic [WORD_W-1:0] wrapped;
        int unsigned     cnt;
        cr  = $signed(cr_word);
        ci  = $signed(ci_word);
        zr  = cr;
        zi  = ci;
        cnt = 1;
        while (cnt < limit) begin
            sq_r   = zr * zr;
            sq_i   = zi * zi;
            mag_sq = longint'(sq_r) + longint'(sq_i);
            if (mag_sq > RADIUS_SQ) break;
            wrapped = WORD_W'(((sq_r - sq_i) >>> FRACTION_BITS) + cr);
            zi      = $signed(WORD_W'(((zr * zi) >>> (FRACTION_BITS - 1)) + ci));
            zr      = $signed(wrapped);
            cnt++;
        end
        return (cnt < limit) ? COUNT_W'(cnt) : '0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_point(
        input logic [WORD_W-1:0]  cr,
        input logic [WORD_W-1:0]  ci,
        input logic               known,
        input logic [COUNT_W-1:0] known_count
    );
        t_pending entry;
        int       idle_cycles;
        idle_cycles = 0;
        while (!no_gaps && $urandom_range(0, 99) < 31) idle_cycles++;
        if (idle_cycles > 0) begin
            point_ch.valid <= 1'b0;
            repeat (idle_cycles) @(posedge i_clk);
        end
        point_ch.valid  <= 1'b1;
        point_ch.c_real <= cr;
        point_ch.c_imag <= ci;
        @(posedge i_clk);
        while (!point_ch.ready) @(posedge i_clk);
        entry.c_real = cr;
        entry.c_imag = ci;
        entry.count  = known ? known_count : escape_count_of(cr, ci, iter_limit);
        pending_counts.push_back(entry);
        n_points++;
    endtask

    task automatic end_burst();
        point_ch.valid <= 1'b0;
        while (n_results != n_points) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] limit);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.iteration_limit <= limit;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        iter_limit = limit;
    endtask

    task automatic random_point(output logic [WORD_W-1:0] cr, output logic [WORD_W-1:0] ci);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            cr = WORD_W'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
            ci = WORD_W'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
        end else if (pick < 75) begin
            cr = WORD_W'($urandom_range(0, 32'h2800_0000)) - 32'h2000_0000;
            ci = WORD_W'($urandom_range(0, 32'h2800_0000)) - 32'h1400_0000;
        end else if (pick < 90) begin
            cr = $urandom;
            ci = $urandom;
        end else begin
            cr = WORD_W'($urandom_range(0, 512)) - 32'd256;
            ci = WORD_W'($urandom_range(0, 512)) - 32'd256;
        end
    endtask

    initial begin
        logic [WORD_W-1:0]  cr;
        logic [WORD_W-1:0]  ci;
        logic [COUNT_W-1:0] limit;
        int                 n_random;
        int                 n_phase;
        int                 phase;

        i_rst_n                = 1'b0;
        point_ch.valid         = 1'b0;
        point_ch.c_real        = '0;
        point_ch.c_imag        = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.iteration_limit = '0;
        iter_limit             = LIMIT_RESET;
        n_points               = 0;
        n_results              = 0;
        n_errors               = 0;
        no_gaps                = 1'b0;
        holdoff_request        = 1'b0;
        n_random               = 0;
        phase                  = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].limit != iter_limit) begin
                end_burst();
                write_limit(directed_rows[r].limit);
            end
            send_point(directed_rows[r].c_real, directed_rows[r].c_imag,
                       directed_rows[r].known, directed_rows[r].count);
        end

        while (n_random < RANDOM_ITEMS) begin
            case (phase % 6)
                0:       limit = COUNT_W'($urandom_range(1, 8));
                1:       limit = COUNT_W'($urandom_range(9, 64));
                2:       limit = LIMIT_RESET;
                3:       limit = COUNT_W'($urandom_range(65, 400));
                4:       limit = COUNT_W'($urandom_range(1, 32));
                default: limit = COUNT_W'($urandom_range(500, 1200));
            endcase
            end_burst();
            write_limit(limit);
            no_gaps = (phase == 2);
            if (phase == 1) holdoff_request = 1'b1;
            n_phase = $urandom_range(40, 90);
            for (int k = 0; k < n_phase; k++) begin
                random_point(cr, ci);
                send_point(cr, ci, 1'b0, '0);
                n_random++;
            end
            phase++;
        end
        end_burst();
        no_gaps = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_counts.size() != 0) begin
            n_errors++;
            $display("%0t: %0d escape counts never delivered", $time, pending_counts.size());
        end
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // The receiver idles at random, except in the no-gap phase and during one long hold-off.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                result_ch.ready <= 1'b0;
            end else if (holdoff_request) begin
                holdoff_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end else if (no_gaps) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= 31);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            n_results++;
            if (pending_counts.size() == 0) begin
                n_errors++;
                $display("%0t: result beat with no point outstanding: expected none, actual %0d",
                         $time, result_ch.escape_count);
            end else begin
                oldest = pending_counts.pop_front();
                if (result_ch.escape_count !== oldest.count) begin
                    n_errors++;
                    $display("%0t: escape_count for c=(%h,%h): expected %0d, actual %0d",
                             $time, oldest.c_real, oldest.c_imag, oldest.count,
                             result_ch.escape_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (point_ch.valid && point_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule

/* mandelbrot_escape_time.f */
src/mbe_pkg.sv
src/mbe_ifs.sv
src/mbe_square.sv
src/mbe_combine.sv
src/mbe_update.sv
src/mandelbrot_escape_time.sv
tb/tb_top.sv
